// ===== sv/fwrbv_pkg.sv =====
// Shared types and constants for the queue with remove-by-value.
package fwrbv_pkg;

   localparam int DEFAULT_DEPTH = 16;
   localparam int WORD_W        = 32;
   localparam int COUNT_OUT_W   = 5;

   localparam logic [1:0] OP_PUSH   = 2'd0;
   localparam logic [1:0] OP_POP    = 2'd1;
   localparam logic [1:0] OP_REMOVE = 2'd2;

   // operation broadcast to every cell, already gated by the accept
   typedef struct packed {
      logic                     push;
      logic                     pop;
      logic                     remove;
      logic signed [WORD_W-1:0] value;
   } ctrl_type;

endpackage

// ===== sv/fifo_with_remove_by_value.sv =====
// Top level: bounded queue of signed words with push, pop and remove-by-value.
//
// Input channel (req_): one item is one operation. req_tuser carries the op
// code (push, pop head, remove first matching word); req_tdata carries the
// word to push or to search for. An item is taken when req_tvalid and
// req_tready are both high at a rising clock edge.
// Result channel (rsp_): exactly one item per accepted operation, giving the
// head word after the operation (0 when empty), the empty flag, the entry
// count, whether a remove deleted a match and whether a push was dropped.
// The result appears in the output register on the cycle after the accept.
// Throughput is one item per cycle while results are taken; every op is
// finished in the accepting cycle by a row of DEPTH cells that compare in
// parallel and shift toward the head, with the first-match flag passed
// cell to cell from the head.
// When the receiver stalls, the waiting result holds and req_tready stays
// low until it is taken; accept and delivery may coincide.
// Reset (synchronous, active high) empties the queue and drops any pending
// result; stored words are not cleared, only the fill count.
module fifo_with_remove_by_value
   import fwrbv_pkg::*;
#(
   parameter int DEPTH = DEFAULT_DEPTH
)(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] value
   input  logic [1:0]  req_tuser,   // [1:0] op
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata    // [31:0] head_value, [32] is_empty,
                                    // [37:33] entry_count, [38] removed,
                                    // [39] overflow
);

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

   logic             accept;
   ctrl_type         ctrl;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             rsp_valid_ff;
   logic [39:0]      rsp_data_ff;

   logic [DEPTH-1:0]             occupied;
   logic [DEPTH-1:0]             tail_here;
   logic [DEPTH:0]               match_chain;
   logic signed [WORD_W-1:0]     cell_data [DEPTH];
   logic signed [WORD_W-1:0]     cell_next [DEPTH];

   logic                     full;
   logic                     overflow;
   logic                     removed;
   logic signed [WORD_W-1:0] head_value;
   logic [CNT_W+COUNT_OUT_W-1:0] count_wide;

   // next item may enter while the pending result is being taken
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      ctrl.push   = 1'b0;
      ctrl.pop    = 1'b0;
      ctrl.remove = 1'b0;
      ctrl.value  = req_tdata[WORD_W-1:0];
      if (accept) begin
         case (req_tuser)
            OP_PUSH:   ctrl.push   = 1'b1;
            OP_POP:    ctrl.pop    = 1'b1;
            OP_REMOVE: ctrl.remove = 1'b1;
            default:   ctrl.push   = 1'b0;  // unused code: no change
         endcase
      end
   end

   assign match_chain[0] = 1'b0;

   for (genvar k = 0; k < DEPTH; k++) begin : g_cell
      logic signed [WORD_W-1:0] neighbor;

      assign occupied[k]  = CNT_W'(k) < count_ff;
      assign tail_here[k] = CNT_W'(k) == count_ff;

      if (k == DEPTH - 1) begin : g_last
         assign neighbor = '0;
      end else begin : g_mid
         assign neighbor = cell_data[k+1];
      end

      fwrbv_cell u_cell (
         .clock     (clock),
         .ctrl      (ctrl),
         .occupied  (occupied[k]),
         .tail_here (tail_here[k]),
         .next_data (neighbor),
         .match_in  (match_chain[k]),
         .match_out (match_chain[k+1]),
         .data_out  (cell_data[k]),
         .data_next (cell_next[k])
      );
   end

   assign full     = count_ff == DEPTH_CNT;
   assign overflow = ctrl.push && full;
   assign removed  = ctrl.remove && match_chain[DEPTH];

   always_comb begin
      count_in = count_ff;
      if (ctrl.push && !full) begin
         count_in = count_ff + 1'b1;
      end else if ((ctrl.pop && count_ff != '0) || removed) begin
         count_in = count_ff - 1'b1;
      end
   end

   assign head_value = (count_in != '0) ? cell_next[0] : '0;
   assign count_wide = {{COUNT_OUT_W{1'b0}}, count_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (accept) begin
         rsp_data_ff <= {overflow, removed, count_wide[COUNT_OUT_W-1:0],
                         (count_in == '0), head_value};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // fill count never goes past the number of cells
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_CNT)
      else $error("fill count beyond depth");

   // a pop of a non-empty queue drops exactly one entry
   a_pop_count : assert property (@(posedge clock) disable iff (reset)
      (ctrl.pop && count_ff != '0) |=> (count_ff + 1'b1 == $past(count_ff)))
      else $error("pop did not drop one entry");

   // every accepted item leaves a result pending in the next cycle
   a_result_follows : assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted item produced no result");

   // an empty result reports a zero head word and a zero count
   a_empty_result : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff[32]) |->
         (rsp_data_ff[31:0] == '0 && rsp_data_ff[37:33] == '0))
      else $error("empty result with stale head or count");

endmodule

// ===== sv/fwrbv_cell.sv =====
// One storage cell of the queue: holds a word, compares, shifts toward the head.
module fwrbv_cell
   import fwrbv_pkg::*;
(
   input  logic                     clock,
   input  ctrl_type                 ctrl,
   input  logic                     occupied,   // cell index below fill count
   input  logic                     tail_here,  // cell index equals fill count
   input  logic signed [WORD_W-1:0] next_data,  // word of the neighbor behind
   input  logic                     match_in,   // a cell nearer the head matched
   output logic                     match_out,
   output logic signed [WORD_W-1:0] data_out,
   output logic signed [WORD_W-1:0] data_next
);

   logic signed [WORD_W-1:0] data_ff;
   logic signed [WORD_W-1:0] data_in;
   logic                     hit;
   logic                     shift;

   assign hit       = ctrl.remove && occupied && (data_ff == ctrl.value);
   assign match_out = match_in || hit;
   // a pop or a remove at or ahead of this cell pulls the neighbor's word in
   assign shift     = occupied && (ctrl.pop || (ctrl.remove && match_out));

   always_comb begin
      if (ctrl.push && tail_here) begin
         data_in = ctrl.value;
      end else if (shift) begin
         data_in = next_data;
      end else begin
         data_in = data_ff;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data_out  = data_ff;
   assign data_next = data_in;

endmodule
